@@ rtl/spi_transfer_coalescer_macros.svh @@
// Assertion macros for the SPI transfer coalescer.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef SPI_TRANSFER_COALESCER_MACROS_SVH
`define SPI_TRANSFER_COALESCER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("coalescer check failed");

// Next-cycle implication, checked outside reset.
`define STC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("coalescer check failed");

`endif

@@ rtl/stc_pkg.sv @@
// Shared constants, types and evaluation functions of the SPI transfer coalescer.
// No dependencies; imported by every module of the block.
`default_nettype none

package stc_pkg;

  // Buffer limits of the controller.
  localparam int HALF_DUPLEX_BYTES = 32;
  localparam int FULL_DUPLEX_BYTES = 16;
  localparam int OPCODE_BYTES      = 4;
  localparam int MAX_TXNS          = 16;

  // Result queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Transaction types.
  localparam logic [1:0] TXN_WRITE  = 2'd0;
  localparam logic [1:0] TXN_READ   = 2'd1;
  localparam logic [1:0] TXN_DUPLEX = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_PARAM   = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  // Register index of the configuration port.
  localparam logic [0:0] REG_IDLE_LEVEL = 1'b0;

  typedef struct packed {
    logic [1:0] txn_type;
    logic [2:0] opcode_bytes;
    logic [5:0] payload_bytes;
    logic [6:0] transfers_merged;
    logic [3:0] txn_index;
    logic [1:0] status;
    logic       plan_done;
  } result_t;

  // One queue entry carries the results of one descriptor.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

  // Outcome of opening a transaction with a descriptor.
  typedef struct packed {
    logic [1:0] status;
    logic [1:0] ttype;
    logic [2:0] opcode;
    logic [5:0] payload;
  } open_t;

  // Outcome of appending a descriptor to the open transaction.
  typedef struct packed {
    logic       ok;
    logic [1:0] ttype;
    logic [5:0] sum;
  } append_t;

  function automatic result_t make_result(input logic [1:0] ttype, input logic [2:0] opcode,
                                          input logic [5:0] payload, input logic [5:0] count,
                                          input logic [3:0] index, input logic [1:0] status,
                                          input logic done);
    result_t r;
    r.txn_type         = ttype;
    r.opcode_bytes     = opcode;
    r.payload_bytes    = payload;
    r.transfers_merged = {1'b0, count};
    r.txn_index        = index;
    r.status           = status;
    r.plan_done        = done;
    return r;
  endfunction

  function automatic result_t make_error(input logic [3:0] index, input logic [1:0] status);
    return make_result(TXN_WRITE, 3'd0, 6'd0, 6'd0, index, status, 1'b1);
  endfunction

  function automatic open_t open_eval(input logic w, input logic r, input logic [7:0] len,
                                      input logic idle);
    open_t o;
    logic [8:0] wr_lim;
    o      = '0;
    wr_lim = 9'(FULL_DUPLEX_BYTES + OPCODE_BYTES) - {8'd0, idle};
    if ((!w && !r) || len == 8'd0) begin
      o.status = ST_BAD_PARAM;
    end else if (w && r) begin
      o.status = ST_UNSUPPORTED;
    end else if (w) begin
      if ({1'b0, len} > wr_lim) begin
        o.status = ST_UNSUPPORTED;
      end else begin
        o.ttype = TXN_WRITE;
        if (len > 8'(OPCODE_BYTES)) begin
          o.opcode = 3'(OPCODE_BYTES);
        end else begin
          o.opcode = len[2:0];
        end
        o.payload = 6'(len - {5'd0, o.opcode});
      end
    end else begin
      if (len > 8'(HALF_DUPLEX_BYTES)) begin
        o.status = ST_UNSUPPORTED;
      end else begin
        o.ttype   = TXN_READ;
        o.payload = len[5:0];
      end
    end
    return o;
  endfunction

  function automatic append_t append_eval(input logic [1:0] cur_type,
                                          input logic [2:0] cur_opcode,
                                          input logic [5:0] cur_payload,
                                          input logic w, input logic r,
                                          input logic [7:0] len, input logic look,
                                          input logic idle);
    append_t a;
    logic [8:0] sum;
    logic [8:0] full_lim;
    logic [8:0] half_idle;
    logic [8:0] half_lim;
    sum       = {3'd0, cur_payload} + {1'b0, len};
    full_lim  = 9'(FULL_DUPLEX_BYTES) - {8'd0, idle};
    half_idle = 9'(HALF_DUPLEX_BYTES) - {8'd0, idle};
    half_lim  = 9'(HALF_DUPLEX_BYTES);
    a.ok      = 1'b1;
    a.ttype   = cur_type;
    a.sum     = sum[5:0];
    if ((!w && !r) || len == 8'd0) begin
      a.ok = 1'b0;
    end else if (w && !r && look) begin
      a.ok = 1'b0;
    end else begin
      case (cur_type)
        TXN_READ: begin
          if (w) begin
            if (cur_opcode == 3'd0 || sum > full_lim) a.ok = 1'b0;
            else a.ttype = TXN_DUPLEX;
          end else if (sum > half_lim) begin
            a.ok = 1'b0;
          end
        end
        TXN_WRITE: begin
          if (w && !r) begin
            if (sum > half_idle) a.ok = 1'b0;
          end else if (r && !w) begin
            if (cur_payload == 6'd0) begin
              if ({1'b0, len} > half_lim) a.ok = 1'b0;
              else a.ttype = TXN_READ;
            end else if (sum <= full_lim) begin
              a.ttype = TXN_DUPLEX;
            end else begin
              a.ok = 1'b0;
            end
          end else begin
            if (sum > full_lim) a.ok = 1'b0;
            else a.ttype = TXN_DUPLEX;
          end
        end
        default: begin
          if (sum > full_lim) a.ok = 1'b0;
        end
      endcase
    end
    return a;
  endfunction

endpackage

`default_nettype wire

@@ rtl/stc_front.sv @@
// Front part: accepts descriptors, tracks the open transaction and builds results.
// Depends on stc_pkg.
`default_nettype none

module stc_front import stc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       has_write,
  input  wire logic       has_read,
  input  wire logic [7:0] length,
  input  wire logic       next_is_duplex,
  input  wire logic       is_last,
  input  wire logic       idle,
  output logic            q_push,
  output entry_t          q_entry
);

  typedef struct packed {
    logic       open;
    logic [1:0] ttype;
    logic [2:0] opcode;
    logic [5:0] payload;
    logic [5:0] count;
    logic [3:0] counter;
    logic       dropping;
  } txn_state_t;

  txn_state_t state;
  txn_state_t state_next;
  open_t      op;
  append_t    ap;
  logic       push_any;
  logic [3:0] idx_inc;
  logic       at_limit;

  // Classify the descriptor against the open transaction.
  always_comb begin
    op       = open_eval(has_write, has_read, length, idle);
    ap       = append_eval(state.ttype, state.opcode, state.payload, has_write, has_read,
                           length, next_is_duplex && !is_last, idle);
    idx_inc  = (state.counter == 4'hF) ? 4'hF : state.counter + 4'd1;
    at_limit = ({1'b0, state.counter} + 5'd1) >= 5'(MAX_TXNS);
    state_next = state;
    push_any   = 1'b0;
    q_entry    = '0;
    if (state.dropping) begin
      if (is_last) state_next.dropping = 1'b0;
    end else if (!state.open) begin
      if (op.status != ST_OK) begin
        push_any            = 1'b1;
        q_entry.first       = make_error(4'd0, op.status);
        state_next          = '0;
        state_next.dropping = !is_last;
      end else if (is_last) begin
        push_any      = 1'b1;
        q_entry.first = make_result(op.ttype, op.opcode, op.payload, 6'd1, 4'd0, ST_OK, 1'b1);
        state_next    = '0;
      end else begin
        state_next.open    = 1'b1;
        state_next.ttype   = op.ttype;
        state_next.opcode  = op.opcode;
        state_next.payload = op.payload;
        state_next.count   = 6'd1;
        state_next.counter = 4'd0;
      end
    end else if (ap.ok) begin
      if (is_last) begin
        push_any      = 1'b1;
        q_entry.first = make_result(ap.ttype, state.opcode, ap.sum, state.count + 6'd1,
                                    state.counter, ST_OK, 1'b1);
        state_next    = '0;
      end else begin
        state_next.ttype   = ap.ttype;
        state_next.payload = ap.sum;
        state_next.count   = state.count + 6'd1;
      end
    end else begin
      // The open transaction closes; the descriptor starts the next one.
      push_any      = 1'b1;
      q_entry.two   = 1'b1;
      q_entry.first = make_result(state.ttype, state.opcode, state.payload, state.count,
                                  state.counter, ST_OK, 1'b0);
      if (at_limit) begin
        q_entry.second      = make_error(idx_inc, ST_UNSUPPORTED);
        state_next          = '0;
        state_next.dropping = !is_last;
      end else if (op.status != ST_OK) begin
        q_entry.second      = make_error(idx_inc, op.status);
        state_next          = '0;
        state_next.dropping = !is_last;
      end else if (is_last) begin
        q_entry.second = make_result(op.ttype, op.opcode, op.payload, 6'd1, idx_inc,
                                     ST_OK, 1'b1);
        state_next     = '0;
      end else begin
        q_entry.two        = 1'b0;
        state_next.open    = 1'b1;
        state_next.ttype   = op.ttype;
        state_next.opcode  = op.opcode;
        state_next.payload = op.payload;
        state_next.count   = 6'd1;
        state_next.counter = idx_inc;
      end
    end
  end

  assign q_push = in_valid && push_any;

  // Transaction state advances on every accepted descriptor.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_valid) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/stc_queue.sv @@
// Short queue of result entries between the front and back parts.
// Depends on stc_pkg.
`default_nettype none

module stc_queue import stc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   deq,
  output entry_t      head,
  output logic        not_empty,
  output logic        full
);

  entry_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_deq;

  assign not_empty = count != '0;
  assign full      = count == QCNT_W'(QUEUE_DEPTH);
  assign do_deq    = deq && not_empty;
  assign head      = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_deq) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !do_deq) count <= count + QCNT_W'(1);
      else if (!push && do_deq) count <= count - QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

@@ rtl/stc_back.sv @@
// Back part: hands out the one or two results of each queue entry in order.
// Depends on stc_pkg.
`default_nettype none

module stc_back import stc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire entry_t head,
  input  wire logic   q_valid,
  input  wire logic   pop,
  output result_t     res,
  output logic        empty,
  output logic        deq
);

  logic second_sel;

  assign empty = !q_valid;
  assign res   = second_sel ? head.second : head.first;
  assign deq   = pop && q_valid && (second_sel || !head.two);

  // Step to the second result of an entry, then release the entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      second_sel <= 1'b0;
    end else if (pop && q_valid) begin
      second_sel <= !second_sel && head.two;
    end
  end

endmodule

`default_nettype wire

@@ rtl/spi_transfer_coalescer.sv @@
// SPI transfer coalescer: packs transfer descriptors into controller transactions.
// Input channel: a descriptor transfer happens at a clock edge with push high and
// full low. Result channel: the oldest result is on the result ports while empty
// is low, and is transferred at a clock edge with pop high.
// The idle_level_known register sits at byte address 0 of the APB port.
// A descriptor is classified in its accept cycle, and its results are registered
// in the result queue. One descriptor is taken per cycle while full is low; the
// result side delivers one result per cycle while pop is high; a descriptor that
// both closes a transaction and opens or fails the next yields two results.
// A four-entry result queue sits between the classifier and the result ports;
// when the receiver stalls, descriptors are still taken until the queue fills,
// and then full stays high until a result entry is released.
// Synchronous reset clears the open transaction, the drop state and the queue,
// and sets idle_level_known to 1. No clearing pass is needed.
// Depends on stc_pkg, stc_front, stc_queue, stc_back and the assertion macros.
`default_nettype none

`include "spi_transfer_coalescer_macros.svh"

module spi_transfer_coalescer import stc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        push,
  output logic             full,
  input  wire logic        has_write,
  input  wire logic        has_read,
  input  wire logic [7:0]  length,
  input  wire logic        next_is_duplex,
  input  wire logic        is_last,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       txn_type,
  output logic [2:0]       opcode_bytes,
  output logic [5:0]       payload_bytes,
  output logic [6:0]       transfers_merged,
  output logic [3:0]       txn_index,
  output logic [1:0]       status,
  output logic             plan_done
);

  logic    idle_level_known;
  logic    in_valid;
  logic    q_push;
  entry_t  q_entry;
  entry_t  q_head;
  logic    q_valid;
  logic    q_deq;
  result_t res;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_level_known <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2:2] == REG_IDLE_LEVEL) begin
      idle_level_known <= pwdata[0];
    end
  end

  assign prdata = (paddr[2:2] == REG_IDLE_LEVEL) ? {31'd0, idle_level_known} : 32'd0;

  assign in_valid = push && !full;

  stc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .has_write      (has_write),
    .has_read       (has_read),
    .length         (length),
    .next_is_duplex (next_is_duplex),
    .is_last        (is_last),
    .idle           (idle_level_known),
    .q_push         (q_push),
    .q_entry        (q_entry)
  );

  stc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .deq        (q_deq),
    .head       (q_head),
    .not_empty  (q_valid),
    .full       (full)
  );

  stc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .q_valid (q_valid),
    .pop     (pop),
    .res     (res),
    .empty   (empty),
    .deq     (q_deq)
  );

  // Result fields.
  assign txn_type         = res.txn_type;
  assign opcode_bytes     = res.opcode_bytes;
  assign payload_bytes    = res.payload_bytes;
  assign transfers_merged = res.transfers_merged;
  assign txn_index        = res.txn_index;
  assign status           = res.status;
  assign plan_done        = res.plan_done;

  // An error result always ends the plan.
  `STC_ASSERT_NOW(a_error_ends_plan, !empty && status != ST_OK, plan_done)
  // A good transaction always holds at least one descriptor.
  `STC_ASSERT_NOW(a_ok_nonempty, !empty && status == ST_OK, transfers_merged != 7'd0)
  // No result appears without an accepted descriptor.
  `STC_ASSERT_NEXT(a_no_invented, empty && !(push && !full), empty)

endmodule

`default_nettype wire

@@ test/spi_transfer_coalescer_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for spi_transfer_coalescer: directed and random descriptor
// sequences, with every result checked against a transaction planner kept in the bench.
// Depends on stc_pkg and the coalescer RTL.

module spi_transfer_coalescer_tb import stc_pkg::*; ();

  typedef struct {
    logic       has_write;
    logic       has_read;
    logic [7:0] length;
    logic       next_is_duplex;
    logic       is_last;
  } descriptor_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic        has_write = 1'b0;
  logic        has_read = 1'b0;
  logic [7:0]  length = '0;
  logic        next_is_duplex = 1'b0;
  logic        is_last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  txn_type;
  logic [2:0]  opcode_bytes;
  logic [5:0]  payload_bytes;
  logic [6:0]  transfers_merged;
  logic [3:0]  txn_index;
  logic [1:0]  status;
  logic        plan_done;

  spi_transfer_coalescer uut (.*);

  always #5 clk = ~clk;

  // Planner state: the open transaction and the plan position.
  int          idle_byte = 1;
  logic        in_txn = 1'b0;
  logic [1:0]  txn_kind = TXN_WRITE;
  int          txn_opcode = 0;
  int          txn_payload = 0;
  int          txn_transfers = 0;
  int          txn_slot = 0;
  logic        skipping = 1'b0;

  descriptor_t pending_descs[$];
  result_t     planned_results[$];
  descriptor_t current_desc;
  int          send_gap_pct = 0;
  int          pop_gap_pct = 0;
  int          send_hold = 0;
  int          pop_hold = 0;
  int          errors = 0;

  function automatic int gap_length(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(15, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic string describe(input result_t res);
    return $sformatf("type %0d opcode %0d payload %0d merged %0d index %0d status %0d done %0d",
                     res.txn_type, res.opcode_bytes, res.payload_bytes, res.transfers_merged,
                     res.txn_index, res.status, res.plan_done);
  endfunction

  function automatic result_t open_txn_result(input logic done);
    result_t res;
    res.txn_type         = txn_kind;
    res.opcode_bytes     = 3'(txn_opcode);
    res.payload_bytes    = 6'(txn_payload);
    res.transfers_merged = 7'(txn_transfers);
    res.txn_index        = 4'(txn_slot);
    res.status           = ST_OK;
    res.plan_done        = done;
    return res;
  endfunction

  function automatic result_t failure_result(input int slot, input logic [1:0] code);
    result_t res;
    res                  = '0;
    res.txn_type         = TXN_WRITE;
    res.txn_index        = 4'((slot > 15) ? 15 : slot);
    res.status           = code;
    res.plan_done        = 1'b1;
    return res;
  endfunction

  function automatic void end_plan();
    in_txn        = 1'b0;
    txn_kind      = TXN_WRITE;
    txn_opcode    = 0;
    txn_payload   = 0;
    txn_transfers = 0;
    txn_slot      = 0;
  endfunction

  // Starts a transaction with the descriptor; returns the status of the attempt.
  function automatic logic [1:0] open_transaction(input descriptor_t d);
    int len;
    len = d.length;
    if ((!d.has_write && !d.has_read) || len == 0) return ST_BAD_PARAM;
    if (d.has_write && d.has_read) return ST_UNSUPPORTED;
    if (d.has_write) begin
      if (len > FULL_DUPLEX_BYTES - idle_byte + OPCODE_BYTES) return ST_UNSUPPORTED;
      txn_kind    = TXN_WRITE;
      txn_opcode  = (len > OPCODE_BYTES) ? OPCODE_BYTES : len;
      txn_payload = len - txn_opcode;
    end else begin
      if (len > HALF_DUPLEX_BYTES) return ST_UNSUPPORTED;
      txn_kind    = TXN_READ;
      txn_opcode  = 0;
      txn_payload = len;
    end
    txn_transfers = 1;
    in_txn        = 1'b1;
    return ST_OK;
  endfunction

  // Plans one accepted descriptor and queues the results it causes.
  task automatic coalesce(input descriptor_t d);
    int         len;
    int         sum;
    int         full_lim;
    logic [1:0] code;
    logic [1:0] next_kind;
    logic       fits;
    logic       w;
    logic       r;
    len      = d.length;
    w        = d.has_write;
    r        = d.has_read;
    sum      = txn_payload + len;
    full_lim = FULL_DUPLEX_BYTES - idle_byte;
    if (skipping) begin
      if (d.is_last) skipping = 1'b0;
      return;
    end
    if (!in_txn) begin
      txn_slot = 0;
      code = open_transaction(d);
      if (code != ST_OK) begin
        planned_results.push_back(failure_result(0, code));
        end_plan();
        skipping = !d.is_last;
        return;
      end
    end else begin
      // Decide whether the descriptor joins the open transaction.
      fits      = 1'b1;
      next_kind = txn_kind;
      if ((!w && !r) || len == 0) begin
        fits = 1'b0;
      end else if (w && !r && d.next_is_duplex && !d.is_last) begin
        fits = 1'b0;
      end else begin
        case (txn_kind)
          TXN_READ: begin
            if (w) begin
              if (txn_opcode == 0 || sum > full_lim) fits = 1'b0;
              else next_kind = TXN_DUPLEX;
            end else if (sum > HALF_DUPLEX_BYTES) begin
              fits = 1'b0;
            end
          end
          TXN_WRITE: begin
            if (w && !r) begin
              if (sum > HALF_DUPLEX_BYTES - idle_byte) fits = 1'b0;
            end else if (r && !w) begin
              if (txn_payload == 0) begin
                if (len > HALF_DUPLEX_BYTES) fits = 1'b0;
                else next_kind = TXN_READ;
              end else if (sum <= full_lim) begin
                next_kind = TXN_DUPLEX;
              end else begin
                fits = 1'b0;
              end
            end else begin
              if (sum > full_lim) fits = 1'b0;
              else next_kind = TXN_DUPLEX;
            end
          end
          default: begin
            if (sum > full_lim) fits = 1'b0;
          end
        endcase
      end
      if (fits) begin
        txn_kind      = next_kind;
        txn_payload   = sum;
        txn_transfers = txn_transfers + 1;
      end else begin
        // Close the open transaction, then start the next one or fail the plan.
        planned_results.push_back(open_txn_result(1'b0));
        if (txn_slot + 1 >= MAX_TXNS) begin
          planned_results.push_back(failure_result(txn_slot + 1, ST_UNSUPPORTED));
          end_plan();
          skipping = !d.is_last;
          return;
        end
        txn_slot = txn_slot + 1;
        code = open_transaction(d);
        if (code != ST_OK) begin
          planned_results.push_back(failure_result(txn_slot, code));
          end_plan();
          skipping = !d.is_last;
          return;
        end
      end
    end
    if (d.is_last) begin
      planned_results.push_back(open_txn_result(1'b1));
      end_plan();
    end
  endtask

  function automatic void enqueue_desc(input logic w, input logic r, input logic [7:0] len,
                                       input logic look, input logic last);
    descriptor_t d;
    d.has_write      = w;
    d.has_read       = r;
    d.length         = len;
    d.next_is_duplex = look;
    d.is_last        = last;
    pending_descs.push_back(d);
  endfunction

  // Descriptor driver: holds each descriptor until its transfer, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        coalesce(current_desc);
        send_hold = gap_length(send_gap_pct);
      end
      if (!push || !full) begin
        if (send_hold > 0) begin
          send_hold = send_hold - 1;
          push <= 1'b0;
        end else if (pending_descs.size() > 0) begin
          current_desc = pending_descs.pop_front();
          push           <= 1'b1;
          has_write      <= current_desc.has_write;
          has_read       <= current_desc.has_read;
          length         <= current_desc.length;
          next_is_duplex <= current_desc.next_is_duplex;
          is_last        <= current_desc.is_last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each popped result against the oldest planned one.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got = {txn_type, opcode_bytes, payload_bytes, transfers_merged, txn_index, status,
               plan_done};
        if (planned_results.size() == 0) begin
          $display("%0t: result with nothing expected: %s", $time, describe(got));
          errors = errors + 1;
        end else begin
          want = planned_results.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected %s, got %s", $time, describe(want),
                     describe(got));
            errors = errors + 1;
          end
        end
        pop_hold = gap_length(pop_gap_pct);
      end
      if (pop_hold > 0) begin
        pop_hold = pop_hold - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Waits until every descriptor is taken and every planned result has arrived.
  task automatic wait_for_drain();
    while (pending_descs.size() != 0 || push || planned_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes idle_level_known over APB and reads it back.
  task automatic set_idle_level(input logic level);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_IDLE_LEVEL);
    pwdata  <= {31'd0, level};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    idle_byte = level;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {31'd0, level}) begin
      $display("%0t: idle_level_known readback: expected %0d, got %0h", $time, level, prdata);
      errors = errors + 1;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int         phase;
    int         count;
    int         seq_len;
    int         k;
    int         pick;
    logic       w;
    logic       r;
    logic       clean;
    logic [7:0] len;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_gap_pct = 20;
    pop_gap_pct  = 20;
    set_idle_level(1'b1);

    // Seventeen transactions in one plan: the last one overflows the plan.
    for (k = 0; k < 17; k++) begin
      if (k % 2 == 0) enqueue_desc(1'b0, 1'b1, 8'd32, 1'b0, k == 16);
      else enqueue_desc(1'b1, 1'b0, 8'd19, 1'b1, 1'b0);
    end
    // Bad descriptor, unsupported duplex open with dropping, and type changes.
    enqueue_desc(1'b0, 1'b0, 8'd0, 1'b0, 1'b1);
    enqueue_desc(1'b1, 1'b1, 8'd8, 1'b0, 1'b0);
    enqueue_desc(1'b0, 1'b1, 8'd255, 1'b1, 1'b1);
    enqueue_desc(1'b1, 1'b0, 8'd19, 1'b0, 1'b0);
    enqueue_desc(1'b0, 1'b1, 8'd1, 1'b0, 1'b0);
    enqueue_desc(1'b1, 1'b0, 8'd2, 1'b0, 1'b0);
    enqueue_desc(1'b0, 1'b1, 8'd32, 1'b0, 1'b0);
    enqueue_desc(1'b1, 1'b1, 8'd1, 1'b0, 1'b1);
    wait_for_drain();

    // Random phases; each starts from an idle block with a new idle setting.
    for (phase = 0; phase < 6; phase++) begin
      send_gap_pct = (phase == 0) ? 0 : $urandom_range(10, 50);
      pop_gap_pct  = (phase == 0) ? 0 : ((phase == 5) ? 70 : $urandom_range(10, 50));
      set_idle_level(1'(phase % 2));
      count = 0;
      while (count < 115) begin
        clean   = $urandom_range(99) < 80;
        seq_len = ($urandom_range(9) == 0) ? $urandom_range(18, 40) : $urandom_range(1, 10);
        for (k = 0; k < seq_len; k++) begin
          pick = $urandom_range(99);
          if (clean) begin
            w   = (pick < 50) || (pick >= 92);
            r   = (pick >= 50);
            len = ($urandom_range(9) == 0) ? 8'($urandom_range(9, 32))
                                           : 8'($urandom_range(1, 8));
          end else begin
            w = 1'($urandom_range(1));
            r = 1'($urandom_range(1));
            if (pick < 10) len = 8'd0;
            else if (pick < 60) len = 8'($urandom_range(1, 20));
            else len = 8'($urandom_range(255));
          end
          enqueue_desc(w, r, len, $urandom_range(3) == 0, k == seq_len - 1);
          count = count + 1;
        end
      end
      wait_for_drain();
    end

    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
